// ----- src/hsvrgb_pkg.sv -----
`timescale 1ns / 1ps

package hsvrgb_pkg;

	localparam int unsigned HueWidth   = 14;
	localparam int unsigned CompWidth  = 16;
	localparam int unsigned TriWidth   = 10;
	localparam int unsigned ProdWidth  = CompWidth + TriWidth;
	localparam int unsigned QuoWidth   = 19;
	localparam int unsigned RecipShift = 24;
	localparam int unsigned RecipWidth = 21;

	localparam logic [HueWidth-1:0]   HueTurn   = 14'd5760;
	localparam logic [HueWidth-1:0]   HueTurn2  = 14'd11520;
	localparam logic [HueWidth-1:0]   HueSector = 14'd960;
	localparam logic [CompWidth-1:0]  QOne      = 16'd32768;
	localparam logic [TriWidth-1:0]   TriFull   = 10'd960;
	// ceil(2^24 / 15); exact floor division by 15 for quotients of 19 bits
	localparam logic [RecipWidth-1:0] Recip15   = 21'd1118482;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HueWidth-1:0]  hue;
		logic [CompWidth-1:0] saturation;
		logic [CompWidth-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [CompWidth-1:0] red;
		logic [CompWidth-1:0] green;
		logic [CompWidth-1:0] blue;
	} rgb_t;

endpackage

// ----- src/hsv_to_rgb_converter_core.sv -----
`timescale 1ns / 1ps

// HSV to RGB color conversion, one word per clock while the output is not stalled.
// Input channel hsv (hsv_valid / hsv_stall) carries hue in 1/16 degree, wrapped
// modulo 360 degrees, and saturation and brightness in Q1.15 (values above 1.0
// are clamped). Output channel rgb (rgb_valid / rgb_stall) carries red, green
// and blue in Q1.15.
// Five register stages: hue wrap and clamp, chroma product and sector split,
// chroma times triangle, division by 960 through a reciprocal multiply, then
// channel select and offset add into the output register. Throughput is one
// word per cycle while the output is not stalled.
// The three multipliers set the stage depth.
// Reset clears all stage valid bits; nothing else is reset.
// When rgb_valid is high and rgb_stall is high the whole pipeline freezes,
// the output word holds, and hsv_stall is raised until the word is taken.
module hsv_to_rgb_converter_core
	import hsvrgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic hsv_valid,
	output logic hsv_stall,
	input  hsv_t hsv,
	output logic rgb_valid,
	input  logic rgb_stall,
	output rgb_t rgb
);

	logic advance;
	assign advance   = !(rgb_valid && rgb_stall);
	assign hsv_stall = !advance;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// stage 1: wrap hue, clamp saturation and brightness
	logic [HueWidth-1:0]  h_s1;
	logic [CompWidth-1:0] s_s1, v_s1;
	logic [HueWidth-1:0]  h_wrap;
	logic [CompWidth-1:0] s_clamp, v_clamp;

	always_comb begin
		if (hsv.hue >= HueTurn2) begin
			h_wrap = hsv.hue - HueTurn2;
		end else if (hsv.hue >= HueTurn) begin
			h_wrap = hsv.hue - HueTurn;
		end else begin
			h_wrap = hsv.hue;
		end
		s_clamp = (hsv.saturation > QOne) ? QOne : hsv.saturation;
		v_clamp = (hsv.brightness > QOne) ? QOne : hsv.brightness;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			h_s1 <= h_wrap;
			s_s1 <= s_clamp;
			v_s1 <= v_clamp;
		end
	end

	// stage 2: chroma, sector, triangle
	logic [2*CompWidth-1:0] vs_prod;
	logic [2:0]             sec_cnt;
	logic [HueWidth-1:0]    sec_base;
	logic [TriWidth-1:0]    frac;
	logic [TriWidth-1:0]    tri_val;
	sector_t                sec;

	logic [CompWidth-1:0] c_s2, v_s2;
	logic [TriWidth-1:0]  tri_s2;
	sector_t              sec_s2;

	always_comb begin
		vs_prod = (2*CompWidth)'(v_s1) * (2*CompWidth)'(s_s1);
		sec_cnt = 3'd0;
		for (int i = 1; i < 6; i++) begin
			if (h_s1 >= HueWidth'(i * 960)) begin
				sec_cnt = 3'(i);
			end
		end
		sec      = sector_t'(sec_cnt);
		sec_base = HueWidth'(sec_cnt * HueSector);
		frac     = TriWidth'(h_s1 - sec_base);
		tri_val  = sec_cnt[0] ? (TriFull - frac) : frac;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			c_s2   <= vs_prod[30:15];
			v_s2   <= v_s1;
			tri_s2 <= tri_val;
			sec_s2 <= sec;
		end
	end

	// stage 3: chroma times triangle
	logic [ProdWidth-1:0] ct_s3;
	logic [CompWidth-1:0] c_s3, v_s3;
	sector_t              sec_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			ct_s3  <= ProdWidth'(c_s2) * ProdWidth'(tri_s2);
			c_s3   <= c_s2;
			v_s3   <= v_s2;
			sec_s3 <= sec_s2;
		end
	end

	// stage 4: divide by 960 = shift by 6, then divide by 15 via reciprocal
	logic [QuoWidth-1:0]              ct_shr;
	logic [QuoWidth+RecipWidth-1:0]   q_prod;
	logic [CompWidth-1:0] x_s4, c_s4, v_s4;
	sector_t              sec_s4;

	always_comb begin
		ct_shr = ct_s3[ProdWidth-2:6];
		q_prod = (QuoWidth+RecipWidth)'(ct_shr) * (QuoWidth+RecipWidth)'(Recip15);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s4   <= q_prod[RecipShift +: CompWidth];
			c_s4   <= c_s3;
			v_s4   <= v_s3;
			sec_s4 <= sec_s3;
		end
	end

	// stage 5: channel select and offset
	logic [CompWidth-1:0] m_val;
	logic [CompWidth-1:0] r_sel, g_sel, b_sel;
	rgb_t                 rgb_s5;

	always_comb begin
		m_val = v_s4 - c_s4;
		case (sec_s4)
			SEC_RY: begin r_sel = c_s4; g_sel = x_s4; b_sel = '0; end
			SEC_YG: begin r_sel = x_s4; g_sel = c_s4; b_sel = '0; end
			SEC_GC: begin r_sel = '0; g_sel = c_s4; b_sel = x_s4; end
			SEC_CB: begin r_sel = '0; g_sel = x_s4; b_sel = c_s4; end
			SEC_BM: begin r_sel = x_s4; g_sel = '0; b_sel = c_s4; end
			default: begin r_sel = c_s4; g_sel = '0; b_sel = x_s4; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rgb_s5.red   <= r_sel + m_val;
			rgb_s5.green <= g_sel + m_val;
			rgb_s5.blue  <= b_sel + m_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= hsv_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign rgb_valid = valid_s5;
	assign rgb       = rgb_s5;

endmodule

// ----- src/hsvrgb_checker.sv -----
`timescale 1ns / 1ps

module hsvrgb_checker
	import hsvrgb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic hsv_valid,
	input logic hsv_stall,
	input hsv_t hsv,
	input logic rgb_valid,
	input logic rgb_stall,
	input rgb_t rgb
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> hsv_valid && $stable(hsv))
		else $error("input word changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
		else $error("output word changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> rgb_valid && rgb_stall)
		else $error("input stalled without a blocked output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> rgb.red <= QOne && rgb.green <= QOne && rgb.blue <= QOne)
		else $error("color component above one");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
		##1 !rgb_stall |=> rgb_valid)
		else $error("accepted word did not reach output");

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_hsvrgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_valid (hsv_valid),
	.hsv_stall (hsv_stall),
	.hsv       (hsv),
	.rgb_valid (rgb_valid),
	.rgb_stall (rgb_stall),
	.rgb       (rgb)
);

// ----- verif/hsv_rgb_checker.sv -----
`timescale 1ns / 1ps

module hsv_rgb_checker
	import hsvrgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic hsv_valid,
	input  logic hsv_stall,
	input  hsv_t hsv,
	input  logic rgb_valid,
	input  logic rgb_stall,
	input  rgb_t rgb,
	output int   errors,
	output int   pending,
	output int   checked
);

	rgb_t rgb_due[$];
	rgb_t want;
	int   err_count  = 0;
	int   word_count = 0;
	int   due_count  = 0;

	assign errors  = err_count;
	assign pending = due_count;
	assign checked = word_count;

	function automatic rgb_t predict_rgb(input hsv_t w);
		logic [HueWidth-1:0]  h;
		logic [TriWidth-1:0]  frac;
		logic [2:0]           sidx;
		logic [CompWidth-1:0] s;
		logic [CompWidth-1:0] v;
		logic [CompWidth-1:0] c;
		logic [CompWidth-1:0] x;
		logic [CompWidth-1:0] m;
		logic [TriWidth-1:0]  ramp;
		logic [31:0]          prod;
		sector_t              sec;
		rgb_t                 o;
		h = w.hue % HueTurn;
		s = (w.saturation > QOne) ? QOne : w.saturation;
		v = (w.brightness > QOne) ? QOne : w.brightness;
		prod = 32'(v) * 32'(s);
		c = CompWidth'(prod >> 15);
		sidx = 3'(h / HueSector);
		sec = sector_t'(sidx);
		frac = TriWidth'(h % HueSector);
		// falling half of the triangle in odd sectors
		ramp = sidx[0] ? TriFull - frac : frac;
		prod = 32'(c) * 32'(ramp);
		x = CompWidth'(prod / TriFull);
		m = v - c;
		case (sec)
			SEC_RY: o = '{red: c + m, green: x + m, blue: m};
			SEC_YG: o = '{red: x + m, green: c + m, blue: m};
			SEC_GC: o = '{red: m, green: c + m, blue: x + m};
			SEC_CB: o = '{red: m, green: x + m, blue: c + m};
			SEC_BM: o = '{red: x + m, green: m, blue: c + m};
			default: o = '{red: c + m, green: m, blue: x + m};
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_due.delete();
			due_count = 0;
		end else begin
			if (rgb_valid && !rgb_stall) begin
				if (rgb_due.size() == 0) begin
					err_count++;
					$error("rgb word with no hsv word pending: %h", rgb);
				end else begin
					want = rgb_due.pop_front();
					word_count++;
					if (rgb.red !== want.red) begin
						err_count++;
						$error("red: expected %0d, actual %0d", want.red, rgb.red);
					end
					if (rgb.green !== want.green) begin
						err_count++;
						$error("green: expected %0d, actual %0d", want.green, rgb.green);
					end
					if (rgb.blue !== want.blue) begin
						err_count++;
						$error("blue: expected %0d, actual %0d", want.blue, rgb.blue);
					end
				end
			end
			if (hsv_valid && !hsv_stall)
				rgb_due.push_back(predict_rgb(hsv));
			due_count = rgb_due.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import hsvrgb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        hsv_valid;
	logic        hsv_stall;
	hsv_t        hsv;
	logic        rgb_valid;
	logic        rgb_stall;
	rgb_t        rgb;
	int          errors;
	int          pending;
	int          checked;
	bit          bursts_on = 0;
	bit          hold_req  = 0;
	int unsigned cycles    = 0;

	hsv_to_rgb_converter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsv_valid(hsv_valid),
		.hsv_stall(hsv_stall),
		.hsv      (hsv),
		.rgb_valid(rgb_valid),
		.rgb_stall(rgb_stall),
		.rgb      (rgb)
	);

	hsv_rgb_checker u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsv_valid(hsv_valid),
		.hsv_stall(hsv_stall),
		.hsv      (hsv),
		.rgb_valid(rgb_valid),
		.rgb_stall(rgb_stall),
		.rgb      (rgb),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [CompWidth-1:0] rand_unit();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return QOne;
			2: return CompWidth'($urandom_range(32769, 65535));
			default: return CompWidth'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [HueWidth-1:0] rand_hue();
		int k;
		k = $urandom_range(0, 17) * 960 - $urandom_range(0, 1);
		if ($urandom_range(0, 3) == 0)
			return HueWidth'(k);
		return HueWidth'($urandom_range(0, 16383));
	endfunction

	task automatic send_word(input hsv_t w);
		int gap;
		if (bursts_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			hsv_valid <= 1'b0;
			hsv       <= '{hue: HueWidth'($urandom), saturation: CompWidth'($urandom),
				brightness: CompWidth'($urandom)};
			repeat (gap) @(negedge clk);
		end
		hsv       <= w;
		hsv_valid <= 1'b1;
		@(posedge clk);
		while (hsv_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int len;
		bit held = 1'b0;
		rgb_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				rgb_stall <= 1'b1;
				repeat (200) @(negedge clk);
				rgb_stall <= 1'b0;
				held = 1'b1;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				len = $urandom_range(1, 12);
				rgb_stall <= 1'b1;
				repeat (len) @(negedge clk);
				rgb_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		hsv_valid = 1'b0;
		hsv       = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sector borders at full color
		send_word(hsv_t'{14'd0,    QOne, QOne});
		send_word(hsv_t'{14'd959,  QOne, QOne});
		send_word(hsv_t'{14'd960,  QOne, QOne});
		send_word(hsv_t'{14'd1919, QOne, QOne});
		send_word(hsv_t'{14'd1920, QOne, QOne});
		send_word(hsv_t'{14'd2879, QOne, QOne});
		send_word(hsv_t'{14'd2880, QOne, QOne});
		send_word(hsv_t'{14'd3840, QOne, QOne});
		send_word(hsv_t'{14'd4800, QOne, QOne});
		send_word(hsv_t'{14'd5759, QOne, QOne});
		// hue wrap past one turn
		send_word(hsv_t'{14'd5760,  16'd20000, 16'd30000});
		send_word(hsv_t'{14'd6720,  16'd12345, 16'd23456});
		send_word(hsv_t'{14'd11520, 16'd32767, 16'd32767});
		send_word(hsv_t'{14'd16383, 16'd30000, 16'd25000});
		// gray, black and clamped saturation / brightness
		send_word(hsv_t'{14'd1234,  16'd0,     16'd20000});
		send_word(hsv_t'{14'd16383, 16'd0,     16'd0});
		send_word(hsv_t'{14'd500,   16'd12345, 16'd0});
		send_word(hsv_t'{14'd1234,  16'd65535, 16'd65535});
		send_word(hsv_t'{14'd3000,  16'd32769, 16'd32769});
		send_word(hsv_t'{14'd4000,  16'd40000, 16'd16384});
		send_word(hsv_t'{14'd4900,  16'd16384, 16'd50000});
		send_word(hsv_t'{14'd7,     16'd1,     16'd1});

		for (int i = 0; i < 500; i++) begin
			if (i % 50 == 0)
				bursts_on = (i < 400) && ($urandom_range(0, 3) != 0);
			if (i == 200)
				hold_req = 1'b1;
			send_word(hsv_t'{rand_hue(), rand_unit(), rand_unit()});
		end
		hsv_valid <= 1'b0;
		bursts_on = 0;

		wait (pending == 0);
		repeat (10) @(posedge clk);
		$display("Checked %0d rgb words: sector borders, hue wrap, clamped inputs,", checked);
		$display("random idle and stall bursts, and a 200-cycle output hold-off.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- hsv_to_rgb_converter_core.f -----
src/hsvrgb_pkg.sv
src/hsv_to_rgb_converter_core.sv
src/hsvrgb_checker.sv
verif/hsv_rgb_checker.sv
verif/tb_top.sv
